FILE: rtl/core/scqra_pkg.sv
`default_nettype none
package scqra_pkg;

  localparam int QUEUE_DEPTH    = 64;
  localparam int NUM_REQUESTERS = 8;
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // Input function codes
  localparam logic [2:0] FN_SUB_BACK  = 3'd0;
  localparam logic [2:0] FN_SUB_FRONT = 3'd1;
  localparam logic [2:0] FN_SUCCEEDED = 3'd2;
  localparam logic [2:0] FN_FAILED    = 3'd3;
  localparam logic [2:0] FN_RETRY_EL  = 3'd4;
  localparam logic [2:0] FN_FORGET    = 3'd5;
  localparam logic [2:0] FN_DISCARD   = 3'd6;
  localparam logic [2:0] FN_COUNT     = 3'd7;

  // Result kinds
  localparam logic [2:0] KIND_DONE    = 3'd0;
  localparam logic [2:0] KIND_ISSUE   = 3'd1;
  localparam logic [2:0] KIND_ABANDON = 3'd2;
  localparam logic [2:0] KIND_RETRY   = 3'd3;
  localparam logic [2:0] KIND_SUMMARY = 3'd4;

  // Done status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_IGNORED  = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // Configuration register indexes
  localparam logic REG_WAIT_WARN  = 1'b0;
  localparam logic REG_DEPTH_WARN = 1'b1;

  // ident: tag [15:0], key [23:16], requester [26:24], max retries [30:27]
  typedef struct packed {
    logic [31:0] wait_tot;
    logic [31:0] enq_ms;
    logic [15:0] delay_ms;
    logic [30:0] ident;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Physical RAM address of logical queue position idx (idx below QUEUE_DEPTH).
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] idx);
    logic [AW:0] s;
    s = {1'b0, head} + (AW+1)'(idx);
    if (s >= (AW+1)'(QUEUE_DEPTH)) begin
      s = s - (AW+1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/scqra_ram.sv
`default_nettype none
module scqra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/shared_command_queue_retry_arbiter_top.sv
`default_nettype none
// Succeeded, failed with abandon, forget, discard of a non-empty queue and count pending walk
// the queue through the single RAM read port; a submit or a check that fails does not.
// Throughput: one item at a time; the next item is taken once the done item is loaded.
// Reset (rst_n, synchronous, active low) empties the queue, frees the slot, clears the
// statistics and sets wait_warn_ms to 1000 and depth_warn_level to 32; the queue RAM is
// not cleared and needs no clearing pass.
module shared_command_queue_retry_arbiter_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // requester[2:0], key_id[10:3], op_tag[26:11], max_retries[30:27],
  // retry_delay_ms[46:31], now_ms[78:47], zero [79]
  input  wire logic [79:0] in_tdata,
  // func[2:0]
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // status[1:0], out_requester[4:2], out_key[12:5], out_tag[28:13], out_delay_ms[44:29],
  // count[51:45], worst_wait_ms[83:52], zero [87:84]
  output logic [87:0]      out_tdata,
  // kind[2:0], depth_warn[3]
  output logic [3:0]       out_tuser,
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  localparam int AW = scqra_pkg::AW;
  localparam int CW = scqra_pkg::CW;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SWEEP   = 3'd1;
  localparam logic [2:0] S_POST    = 3'd2;
  localparam logic [2:0] S_DISP    = 3'd3;
  localparam logic [2:0] S_DISP2   = 3'd4;
  localparam logic [2:0] S_IDLECHK = 3'd5;
  localparam logic [2:0] S_SLOTOUT = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  // input fields
  logic [2:0]  in_func;
  logic [2:0]  in_req;
  logic [7:0]  in_key;
  logic [15:0] in_tag;
  logic [3:0]  in_maxr;
  logic [15:0] in_delay;
  logic [31:0] in_now;
  assign in_func  = in_tuser;
  assign in_req   = in_tdata[2:0];
  assign in_key   = in_tdata[10:3];
  assign in_tag   = in_tdata[26:11];
  assign in_maxr  = in_tdata[30:27];
  assign in_delay = in_tdata[46:31];
  assign in_now   = in_tdata[78:47];

  logic [2:0]  state_r, state_nxt;
  logic [2:0]  func_r, func_nxt;
  logic [2:0]  req_r, req_nxt;
  logic [7:0]  key_r, key_nxt;
  logic [31:0] now_r, now_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [1:0]  status_r, status_nxt;
  logic        warn_r, warn_nxt;
  logic        chg_r, chg_nxt;
  logic [2:0]  kind_r, kind_nxt;

  logic [15:0] wait_warn_r, wait_warn_nxt;
  logic [6:0]  level_r, level_nxt;

  logic [CW-1:0] len_r, len_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic          slot_valid_r, slot_valid_nxt;
  logic [30:0]   slot_ident_r, slot_ident_nxt;
  logic [15:0]   slot_delay_r, slot_delay_nxt;
  logic [31:0]   slot_since_r, slot_since_nxt;
  logic [3:0]    retries_r, retries_nxt;
  logic          rwait_r, rwait_nxt;
  logic [6:0]    delayed_r, delayed_nxt;
  logic [31:0]   worst_r, worst_nxt;
  logic          dwarned_r, dwarned_nxt;

  logic [CW-1:0]      rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]      j_r, j_nxt;
  logic               pv_r, pv_nxt;
  logic               s2v_r, s2v_nxt;
  scqra_pkg::entry_t  s2_ent_r, s2_ent_nxt;
  logic [31:0]        s2_w_r, s2_w_nxt;
  logic               s2_match_r, s2_match_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [87:0] out_data_r, out_data_nxt;
  logic [3:0]  out_user_r, out_user_nxt;
  logic        out_last_r, out_last_nxt;

  // RAM port
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  scqra_pkg::entry_t  ram_wdata, ram_rdata;

  scqra_ram #(
    .WIDTH(scqra_pkg::ENTRY_W),
    .DEPTH(scqra_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  logic        can_push, push;
  logic [2:0]  p_kind;
  logic [1:0]  p_status;
  logic [30:0] p_ident;
  logic [15:0] p_delay;
  logic [6:0]  p_count;
  logic [31:0] p_worst;
  logic        p_last;

  assign can_push = !out_valid_r || out_tready;

  logic [CW:0]   len_inc;
  logic [AW-1:0] head_dec, head_inc;
  logic          own;
  logic          sweep_end;
  logic [2:0]    after_disp;
  scqra_pkg::entry_t e_new, e1;
  logic [31:0]   from_ms;
  logic [32:0]   wsum;

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    req_nxt        = req_r;
    key_nxt        = key_r;
    now_nxt        = now_r;
    cnt_nxt        = cnt_r;
    status_nxt     = status_r;
    warn_nxt       = warn_r;
    chg_nxt        = chg_r;
    kind_nxt       = kind_r;
    wait_warn_nxt  = wait_warn_r;
    level_nxt      = level_r;
    len_nxt        = len_r;
    head_nxt       = head_r;
    slot_valid_nxt = slot_valid_r;
    slot_ident_nxt = slot_ident_r;
    slot_delay_nxt = slot_delay_r;
    slot_since_nxt = slot_since_r;
    retries_nxt    = retries_r;
    rwait_nxt      = rwait_r;
    delayed_nxt    = delayed_r;
    worst_nxt      = worst_r;
    dwarned_nxt    = dwarned_r;
    rd_idx_nxt     = rd_idx_r;
    j_nxt          = j_r;
    pv_nxt         = pv_r;
    s2v_nxt        = s2v_r;
    s2_ent_nxt     = s2_ent_r;
    s2_w_nxt       = s2_w_r;
    s2_match_nxt   = s2_match_r;

    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = '0;
    ram_raddr = '0;
    ram_wdata = '0;

    push     = 1'b0;
    p_kind   = scqra_pkg::KIND_DONE;
    p_status = scqra_pkg::ST_OK;
    p_ident  = '0;
    p_delay  = '0;
    p_count  = '0;
    p_worst  = '0;
    p_last   = 1'b0;

    e_new    = '0;
    e1       = ram_rdata;
    from_ms  = '0;
    wsum     = '0;

    len_inc  = {1'b0, len_r} + (CW+1)'(1);
    head_dec = (head_r == '0) ? AW'(scqra_pkg::QUEUE_DEPTH - 1) : head_r - AW'(1);
    head_inc = (head_r == AW'(scqra_pkg::QUEUE_DEPTH - 1)) ? '0 : head_r + AW'(1);
    own      = slot_valid_r && (slot_ident_r[26:24] == in_req);
    sweep_end = !pv_r && !s2v_r && (rd_idx_r >= len_r);
    after_disp = ((func_r == scqra_pkg::FN_SUCCEEDED) || (func_r == scqra_pkg::FN_FAILED) ||
                  (func_r == scqra_pkg::FN_FORGET)) ? S_IDLECHK : S_DONE;

    if (cfg_we) begin
      case (cfg_addr[0])
        scqra_pkg::REG_WAIT_WARN:  wait_warn_nxt = cfg_wdata;
        scqra_pkg::REG_DEPTH_WARN: level_nxt = cfg_wdata[6:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          func_nxt   = in_func;
          req_nxt    = in_req;
          key_nxt    = in_key;
          now_nxt    = in_now;
          cnt_nxt    = '0;
          status_nxt = scqra_pkg::ST_OK;
          warn_nxt   = 1'b0;
          chg_nxt    = 1'b0;
          rd_idx_nxt = '0;
          j_nxt      = '0;
          pv_nxt     = 1'b0;
          s2v_nxt    = 1'b0;
          case (in_func)
            scqra_pkg::FN_SUB_BACK, scqra_pkg::FN_SUB_FRONT: begin
              if (in_req == '0 ||
                  {29'd0, in_req} >= 32'(scqra_pkg::NUM_REQUESTERS)) begin
                status_nxt = scqra_pkg::ST_REJECTED;
                state_nxt  = S_DONE;
              end else if (len_r == CW'(scqra_pkg::QUEUE_DEPTH)) begin
                status_nxt = scqra_pkg::ST_FULL;
                state_nxt  = S_DONE;
              end else begin
                e_new.ident    = {in_maxr, in_req, in_key, in_tag};
                e_new.delay_ms = in_delay;
                e_new.enq_ms   = in_now;
                e_new.wait_tot = '0;
                ram_we    = 1'b1;
                ram_wdata = e_new;
                if (in_func == scqra_pkg::FN_SUB_FRONT) begin
                  ram_waddr = head_dec;
                  head_nxt  = head_dec;
                end else begin
                  ram_waddr = scqra_pkg::phys(head_r, len_r);
                end
                len_nxt = len_inc[CW-1:0];
                // Warning rises at the level and re-arms at half of it.
                if ({{(31-CW){1'b0}}, len_inc} >= {25'd0, level_r}) begin
                  if (!dwarned_r) begin
                    dwarned_nxt = 1'b1;
                    warn_nxt    = 1'b1;
                  end
                end else if ({{(31-CW){1'b0}}, len_inc} <= {26'd0, level_r[6:1]}) begin
                  dwarned_nxt = 1'b0;
                end
                state_nxt = S_DISP;
              end
            end
            scqra_pkg::FN_SUCCEEDED: begin
              if (!own) begin
                status_nxt = scqra_pkg::ST_IGNORED;
                state_nxt  = S_DONE;
              end else begin
                chg_nxt   = 1'b1;
                state_nxt = S_SWEEP;
              end
            end
            scqra_pkg::FN_FAILED: begin
              if (!own || rwait_r) begin
                status_nxt = scqra_pkg::ST_IGNORED;
                state_nxt  = S_DONE;
              end else if (retries_r < slot_ident_r[30:27]) begin
                retries_nxt = retries_r + 4'd1;
                rwait_nxt   = 1'b1;
                kind_nxt    = scqra_pkg::KIND_RETRY;
                state_nxt   = S_SLOTOUT;
              end else begin
                chg_nxt   = 1'b1;
                state_nxt = S_SWEEP;
              end
            end
            scqra_pkg::FN_RETRY_EL: begin
              if (!own || !rwait_r) begin
                status_nxt = scqra_pkg::ST_IGNORED;
                state_nxt  = S_DONE;
              end else begin
                rwait_nxt = 1'b0;
                kind_nxt  = scqra_pkg::KIND_ISSUE;
                state_nxt = S_SLOTOUT;
              end
            end
            scqra_pkg::FN_FORGET: begin
              chg_nxt   = own;
              state_nxt = S_SWEEP;
            end
            scqra_pkg::FN_DISCARD: begin
              state_nxt = (len_r == '0) ? S_DONE : S_SWEEP;
            end
            default: begin
              state_nxt = S_SWEEP;
            end
          endcase
        end
      end

      S_SWEEP: begin
        // Read stage
        if (rd_idx_r < len_r) begin
          ram_re     = 1'b1;
          ram_raddr  = scqra_pkg::phys(head_r, rd_idx_r);
          rd_idx_nxt = rd_idx_r + CW'(1);
          pv_nxt     = 1'b1;
        end else begin
          pv_nxt = 1'b0;
        end
        // Wait stage: time this entry waited behind the holder
        s2v_nxt = pv_r;
        if (pv_r) begin
          from_ms = (e1.enq_ms > slot_since_r) ? e1.enq_ms : slot_since_r;
          s2_ent_nxt = e1;
          s2_w_nxt   = (chg_r && (e1.ident[26:24] != slot_ident_r[26:24]) && (now_r > from_ms))
                       ? now_r - from_ms : '0;
          if (func_r == scqra_pkg::FN_DISCARD) begin
            s2_match_nxt = (e1.ident[26:24] == req_r) && (e1.ident[23:16] == key_r);
          end else begin
            s2_match_nxt = (e1.ident[26:24] == req_r);
          end
        end
        // Update and write-back stage
        if (s2v_r) begin
          if (func_r == scqra_pkg::FN_COUNT) begin
            if (s2_match_r) cnt_nxt = cnt_r + 7'd1;
          end else if (s2_match_r && ((func_r == scqra_pkg::FN_FORGET) ||
                                      (func_r == scqra_pkg::FN_DISCARD))) begin
            cnt_nxt = cnt_r + 7'd1;
          end else begin
            wsum = {1'b0, s2_ent_r.wait_tot} + {1'b0, s2_w_r};
            e_new = s2_ent_r;
            e_new.wait_tot = wsum[32] ? 32'hFFFF_FFFF : wsum[31:0];
            ram_we    = 1'b1;
            ram_waddr = scqra_pkg::phys(head_r, j_r);
            ram_wdata = e_new;
            j_nxt     = j_r + CW'(1);
          end
        end
        if (sweep_end) begin
          if (func_r != scqra_pkg::FN_COUNT) len_nxt = j_r;
          state_nxt = S_POST;
        end
      end

      S_POST: begin
        case (func_r)
          scqra_pkg::FN_SUCCEEDED: begin
            slot_valid_nxt = 1'b0;
            slot_ident_nxt = '0;
            slot_delay_nxt = '0;
            retries_nxt    = '0;
            rwait_nxt      = 1'b0;
            state_nxt      = S_DISP;
          end
          scqra_pkg::FN_FAILED: begin
            if (can_push) begin
              push           = 1'b1;
              p_kind         = scqra_pkg::KIND_ABANDON;
              p_ident        = slot_ident_r;
              slot_valid_nxt = 1'b0;
              slot_ident_nxt = '0;
              slot_delay_nxt = '0;
              retries_nxt    = '0;
              rwait_nxt      = 1'b0;
              state_nxt      = S_DISP;
            end
          end
          scqra_pkg::FN_FORGET: begin
            if (chg_r) begin
              cnt_nxt        = cnt_r + 7'd1;
              slot_valid_nxt = 1'b0;
              slot_ident_nxt = '0;
              slot_delay_nxt = '0;
              retries_nxt    = '0;
              rwait_nxt      = 1'b0;
            end
            state_nxt = S_DISP;
          end
          scqra_pkg::FN_DISCARD: state_nxt = S_IDLECHK;
          default:               state_nxt = S_DONE;
        endcase
      end

      S_DISP: begin
        if (slot_valid_r || len_r == '0) begin
          state_nxt = after_disp;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = head_r;
          state_nxt = S_DISP2;
        end
      end

      S_DISP2: begin
        if (can_push) begin
          push           = 1'b1;
          p_kind         = scqra_pkg::KIND_ISSUE;
          p_ident        = e1.ident;
          slot_valid_nxt = 1'b1;
          slot_ident_nxt = e1.ident;
          slot_delay_nxt = e1.delay_ms;
          slot_since_nxt = now_r;
          retries_nxt    = '0;
          rwait_nxt      = 1'b0;
          head_nxt       = head_inc;
          len_nxt        = len_r - CW'(1);
          if (e1.wait_tot >= {16'd0, wait_warn_r}) begin
            if (delayed_r != 7'h7F) delayed_nxt = delayed_r + 7'd1;
            if (e1.wait_tot > worst_r) worst_nxt = e1.wait_tot;
          end
          state_nxt = after_disp;
        end
      end

      S_IDLECHK: begin
        if (slot_valid_r || len_r != '0 || delayed_r == '0) begin
          state_nxt = S_DONE;
        end else if (can_push) begin
          push        = 1'b1;
          p_kind      = scqra_pkg::KIND_SUMMARY;
          p_count     = delayed_r;
          p_worst     = worst_r;
          delayed_nxt = '0;
          worst_nxt   = '0;
          state_nxt   = S_DONE;
        end
      end

      S_SLOTOUT: begin
        if (can_push) begin
          push      = 1'b1;
          p_kind    = kind_r;
          p_ident   = slot_ident_r;
          p_delay   = (kind_r == scqra_pkg::KIND_RETRY) ? slot_delay_r : '0;
          state_nxt = S_DONE;
        end
      end

      default: begin
        if (can_push) begin
          push      = 1'b1;
          p_kind    = scqra_pkg::KIND_DONE;
          p_status  = status_r;
          p_count   = cnt_r;
          p_last    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
    endcase

    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {4'd0, p_worst, p_count, p_delay, p_ident[15:0], p_ident[23:16],
                       p_ident[26:24], p_status};
      out_user_nxt  = {warn_r, p_kind};
      out_last_nxt  = p_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wait_warn_r  <= 16'd1000;
      level_r      <= 7'd32;
      len_r        <= '0;
      head_r       <= '0;
      slot_valid_r <= 1'b0;
      slot_ident_r <= '0;
      slot_delay_r <= '0;
      slot_since_r <= '0;
      retries_r    <= '0;
      rwait_r      <= 1'b0;
      delayed_r    <= '0;
      worst_r      <= '0;
      dwarned_r    <= 1'b0;
      pv_r         <= 1'b0;
      s2v_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wait_warn_r  <= wait_warn_nxt;
      level_r      <= level_nxt;
      len_r        <= len_nxt;
      head_r       <= head_nxt;
      slot_valid_r <= slot_valid_nxt;
      slot_ident_r <= slot_ident_nxt;
      slot_delay_r <= slot_delay_nxt;
      slot_since_r <= slot_since_nxt;
      retries_r    <= retries_nxt;
      rwait_r      <= rwait_nxt;
      delayed_r    <= delayed_nxt;
      worst_r      <= worst_nxt;
      dwarned_r    <= dwarned_nxt;
      pv_r         <= pv_nxt;
      s2v_r        <= s2v_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    req_r      <= req_nxt;
    key_r      <= key_nxt;
    now_r      <= now_nxt;
    cnt_r      <= cnt_nxt;
    status_r   <= status_nxt;
    warn_r     <= warn_nxt;
    chg_r      <= chg_nxt;
    kind_r     <= kind_nxt;
    rd_idx_r   <= rd_idx_nxt;
    j_r        <= j_nxt;
    s2_ent_r   <= s2_ent_nxt;
    s2_w_r     <= s2_w_nxt;
    s2_match_r <= s2_match_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= CW'(scqra_pkg::QUEUE_DEPTH))
    else $error("queue length beyond depth");

  a_retry_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    rwait_r |-> slot_valid_r)
    else $error("retry pending without a held slot");

  a_last_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_user_r[2:0] == scqra_pkg::KIND_DONE))
    else $error("final item of a step is not a done status");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("new item taken before the previous one finished");

endmodule
`default_nettype wire

FILE: tb/testbench.sv
module testbench;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we;
  logic [0:0]  cfg_addr;
  logic [15:0] cfg_wdata;

  shared_command_queue_retry_arbiter_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // Expected output item: tuser and tdata and tlast as the block packs them.
  typedef struct packed {
    logic [3:0]  user;
    logic [87:0] data;
    logic        lst;
  } result_t;

  result_t expected_results[$];
  int      errors;
  bit      hold_off;
  int      hold_cnt;

  // Shadow of the queue and slot.
  logic [30:0] q_ident[$];
  logic [15:0] q_delay[$];
  logic [31:0] q_enq[$];
  logic [31:0] q_wait[$];
  logic        s_valid;
  logic [30:0] s_ident;
  logic [15:0] s_delay;
  logic [31:0] s_since;
  logic [3:0]  s_used;
  logic        s_retry_wait;
  logic [6:0]  n_delayed;
  logic [31:0] worst;
  logic        warned;
  logic [15:0] warn_wait;
  logic [6:0]  warn_depth;

  // Items of the current step before warn/last are stamped.
  logic [2:0]  st_kind[$];
  logic [87:0] st_data[$];

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [2:0] req_of(logic [30:0] id);
    return id[26:24];
  endfunction

  function automatic void emit(logic [2:0] kind, logic [1:0] status, logic [30:0] id,
                               logic [15:0] dly, logic [6:0] cnt, logic [31:0] w);
    st_kind.push_back(kind);
    st_data.push_back({4'b0, w, cnt, dly, id[15:0], id[23:16], id[26:24], status});
  endfunction

  function automatic void charge_waits(logic [31:0] now);
    logic [31:0] from;
    logic [32:0] sum;
    if (!s_valid) return;
    foreach (q_ident[i]) begin
      if (req_of(q_ident[i]) != req_of(s_ident)) begin
        from = (q_enq[i] > s_since) ? q_enq[i] : s_since;
        if (now > from) begin
          sum = {1'b0, q_wait[i]} + (now - from);
          q_wait[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
      end
    end
  endfunction

  function automatic void free_slot();
    s_valid = 0; s_ident = '0; s_delay = '0; s_used = '0; s_retry_wait = 0;
  endfunction

  function automatic void issue_front(logic [31:0] now);
    logic [31:0] w;
    if (s_valid || q_ident.size() == 0) return;
    s_ident = q_ident.pop_front();
    s_delay = q_delay.pop_front();
    void'(q_enq.pop_front());
    w = q_wait.pop_front();
    s_valid = 1; s_used = '0; s_retry_wait = 0; s_since = now;
    if (w >= warn_wait) begin
      if (n_delayed < 7'd127) n_delayed++;
      if (w > worst) worst = w;
    end
    emit(scqra_pkg::KIND_ISSUE, scqra_pkg::ST_OK, s_ident, '0, '0, '0);
  endfunction

  function automatic void report_idle();
    if (s_valid || q_ident.size() != 0 || n_delayed == 0) return;
    emit(scqra_pkg::KIND_SUMMARY, scqra_pkg::ST_OK, '0, '0, n_delayed, worst);
    n_delayed = '0; worst = '0;
  endfunction

  function automatic void drop_at(int i);
    q_ident.delete(i); q_delay.delete(i); q_enq.delete(i); q_wait.delete(i);
  endfunction

  function automatic void predict_arbiter(logic [2:0] fn, logic [79:0] d);
    logic [2:0]  rq;
    logic [7:0]  ky;
    logic [15:0] tg;
    logic [3:0]  mx;
    logic [15:0] dl;
    logic [31:0] now;
    logic [30:0] id;
    logic [1:0]  status;
    logic [6:0]  cnt;
    logic        warn;
    int          i;
    rq = d[2:0]; ky = d[10:3]; tg = d[26:11]; mx = d[30:27]; dl = d[46:31]; now = d[78:47];
    status = scqra_pkg::ST_OK; cnt = '0; warn = 0;
    st_kind.delete(); st_data.delete();
    case (fn)
      scqra_pkg::FN_SUB_BACK, scqra_pkg::FN_SUB_FRONT: begin
        if (rq == 0) status = scqra_pkg::ST_REJECTED;
        else if (q_ident.size() >= scqra_pkg::QUEUE_DEPTH) status = scqra_pkg::ST_FULL;
        else begin
          id = {mx, rq, ky, tg};
          if (fn == scqra_pkg::FN_SUB_FRONT) begin
            q_ident.push_front(id); q_delay.push_front(dl);
            q_enq.push_front(now); q_wait.push_front('0);
          end else begin
            q_ident.push_back(id); q_delay.push_back(dl);
            q_enq.push_back(now); q_wait.push_back('0);
          end
          if (q_ident.size() >= warn_depth) begin
            if (!warned) begin
              warned = 1; warn = 1;
            end
          end else if (q_ident.size() <= warn_depth / 2) begin
            warned = 0;
          end
          issue_front(now);
        end
      end
      scqra_pkg::FN_SUCCEEDED: begin
        if (!s_valid || req_of(s_ident) != rq) status = scqra_pkg::ST_IGNORED;
        else begin
          charge_waits(now);
          free_slot();
          issue_front(now);
          report_idle();
        end
      end
      scqra_pkg::FN_FAILED: begin
        if (!s_valid || req_of(s_ident) != rq || s_retry_wait) status = scqra_pkg::ST_IGNORED;
        else if (s_used < s_ident[30:27]) begin
          s_used++;
          s_retry_wait = 1;
          emit(scqra_pkg::KIND_RETRY, scqra_pkg::ST_OK, s_ident, s_delay, '0, '0);
        end else begin
          charge_waits(now);
          id = s_ident;
          free_slot();
          emit(scqra_pkg::KIND_ABANDON, scqra_pkg::ST_OK, id, '0, '0, '0);
          issue_front(now);
          report_idle();
        end
      end
      scqra_pkg::FN_RETRY_EL: begin
        if (!s_valid || req_of(s_ident) != rq || !s_retry_wait) status = scqra_pkg::ST_IGNORED;
        else begin
          s_retry_wait = 0;
          emit(scqra_pkg::KIND_ISSUE, scqra_pkg::ST_OK, s_ident, '0, '0, '0);
        end
      end
      scqra_pkg::FN_FORGET: begin
        i = 0;
        while (i < q_ident.size()) begin
          if (req_of(q_ident[i]) == rq) begin
            drop_at(i); cnt++;
          end else i++;
        end
        if (s_valid && req_of(s_ident) == rq) begin
          charge_waits(now);
          cnt++;
          free_slot();
        end
        issue_front(now);
        report_idle();
      end
      scqra_pkg::FN_DISCARD: begin
        if (q_ident.size() != 0) begin
          i = 0;
          while (i < q_ident.size()) begin
            if (req_of(q_ident[i]) == rq && q_ident[i][23:16] == ky) begin
              drop_at(i); cnt++;
            end else i++;
          end
          report_idle();
        end
      end
      default: begin
        foreach (q_ident[j]) if (req_of(q_ident[j]) == rq) cnt++;
      end
    endcase
    emit(scqra_pkg::KIND_DONE, status, '0, '0, cnt, '0);
    foreach (st_kind[k])
      expected_results.push_back('{{warn, st_kind[k]}, st_data[k], k == st_kind.size() - 1});
  endfunction

  // Result checker.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result user=%h data=%h last=%b", $time,
                 out_tuser, out_tdata, out_tlast);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_tuser !== want.user) begin
          $display("%0t: kind/warn mismatch expected %h actual %h", $time, want.user, out_tuser);
          errors++;
        end
        if (out_tdata !== want.data) begin
          $display("%0t: data mismatch expected %h actual %h", $time, want.data, out_tdata);
          errors++;
        end
        if (out_tlast !== want.lst) begin
          $display("%0t: last mismatch expected %b actual %b", $time, want.lst, out_tlast);
          errors++;
        end
      end
    end
  end

  // Receiver stalls on its own pattern; once asked, it holds off for a long stretch that it
  // counts itself.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_cnt   <= 0;
    end else if (hold_off && hold_cnt < 400) begin
      out_tready <= 1'b0;
      hold_cnt   <= hold_cnt + 1;
    end else out_tready <= ($urandom_range(0, 3) != 0) || ($time / 4000) % 2 == 1;
  end

  int burst_left;

  task automatic send_item(logic [2:0] fn, logic [2:0] rq, logic [7:0] ky, logic [15:0] tg,
                           logic [3:0] mx, logic [15:0] dl, logic [31:0] now);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {1'b0, now, dl, mx, tg, ky, rq};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_arbiter(fn, {1'b0, now, dl, mx, tg, ky, rq});
    in_tvalid <= 1'b0;
    // The block is busy for at least this cycle after taking an item.
    @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == scqra_pkg::REG_WAIT_WARN) warn_wait = val;
    else warn_depth = val[6:0];
  endtask

  logic [31:0] clock_ms;

  function automatic logic [31:0] tick();
    clock_ms = clock_ms + $urandom_range(0, 3000);
    return clock_ms;
  endfunction

  task automatic test_directed();
    send_item(scqra_pkg::FN_SUB_BACK, 3'd0, 8'hFF, 16'hFFFF, 4'hF, 16'hFFFF, tick());
    send_item(scqra_pkg::FN_SUB_BACK, 3'd1, 8'h00, 16'h0000, 4'd1, 16'h0000, tick());
    send_item(scqra_pkg::FN_SUB_BACK, 3'd7, 8'hFF, 16'hFFFF, 4'hF, 16'hFFFF, tick());
    send_item(scqra_pkg::FN_SUB_FRONT, 3'd2, 8'h5A, 16'h1234, 4'd0, 16'd50, tick());
    send_item(scqra_pkg::FN_COUNT, 3'd7, 8'h0, 16'h0, 4'h0, 16'h0, tick());
    send_item(scqra_pkg::FN_SUCCEEDED, 3'd3, 8'h0, 16'h0, 4'h0, 16'h0, tick());
    send_item(scqra_pkg::FN_RETRY_EL, 3'd1, 8'h0, 16'h0, 4'h0, 16'h0, tick());
    send_item(scqra_pkg::FN_FAILED, 3'd1, 8'h0, 16'h0, 4'h0, 16'h0, tick());
    send_item(scqra_pkg::FN_FAILED, 3'd1, 8'h0, 16'h0, 4'h0, 16'h0, tick());
    send_item(scqra_pkg::FN_RETRY_EL, 3'd1, 8'h0, 16'h0, 4'h0, 16'h0, tick());
    send_item(scqra_pkg::FN_FAILED, 3'd1, 8'h0, 16'h0, 4'h0, 16'h0, 32'hFFFF_FFF0);
    send_item(scqra_pkg::FN_DISCARD, 3'd7, 8'h11, 16'h0, 4'h0, 16'h0, 32'hFFFF_FFFF);
    send_item(scqra_pkg::FN_DISCARD, 3'd7, 8'hFF, 16'h0, 4'h0, 16'h0, 32'hFFFF_FFFF);
    send_item(scqra_pkg::FN_FORGET, 3'd2, 8'h0, 16'h0, 4'h0, 16'h0, 32'hFFFF_FFFF);
    send_item(scqra_pkg::FN_FORGET, 3'd5, 8'h0, 16'h0, 4'h0, 16'h0, 32'hFFFF_FFFF);
    send_item(scqra_pkg::FN_DISCARD, 3'd5, 8'h0, 16'h0, 4'h0, 16'h0, 32'h0);
    clock_ms = 0;
  endtask

  // Fill the queue past full while the receiver holds off, then drain it.
  task automatic test_full_queue();
    int n;
    write_reg(scqra_pkg::REG_DEPTH_WARN, 7'd64);
    write_reg(scqra_pkg::REG_WAIT_WARN, 16'd0);
    hold_off = 1;
    for (n = 0; n < 66; n++)
      send_item(n[0] ? scqra_pkg::FN_SUB_FRONT : scqra_pkg::FN_SUB_BACK,
                3'($urandom_range(1, 7)),
                8'($urandom), 16'($urandom), 4'($urandom), 16'($urandom), tick());
    for (n = 1; n < 8; n++)
      send_item(scqra_pkg::FN_FORGET, 3'(n), 8'h0, 16'h0, 4'h0, 16'h0, tick());
  endtask

  // Mostly well-formed operation lifecycles on a few requesters, with noise.
  task automatic test_random(int items);
    int          n;
    logic [2:0]  fn;
    logic [2:0]  rq;
    for (n = 0; n < items; n++) begin
      rq = (s_valid && $urandom_range(0, 2) != 0) ? req_of(s_ident)
           : 3'($urandom_range(0, 7));
      case ($urandom_range(0, 11))
        0, 1, 2: fn = scqra_pkg::FN_SUB_BACK;
        3:       fn = scqra_pkg::FN_SUB_FRONT;
        4, 5:    fn = scqra_pkg::FN_SUCCEEDED;
        6, 7:    fn = scqra_pkg::FN_FAILED;
        8:       fn = scqra_pkg::FN_RETRY_EL;
        9:       fn = scqra_pkg::FN_FORGET;
        10:      fn = scqra_pkg::FN_DISCARD;
        default: fn = scqra_pkg::FN_COUNT;
      endcase
      if (fn == scqra_pkg::FN_RETRY_EL && s_retry_wait) rq = req_of(s_ident);
      send_item(fn, rq, 8'($urandom_range(0, 3)) | ($urandom_range(0, 7) == 0 ? 8'hFC : 8'h0),
                16'($urandom), 4'($urandom_range(0, 3)) | ($urandom_range(0, 9) == 0 ? 4'hC : 4'h0),
                16'($urandom), ($urandom_range(0, 19) == 0) ? $urandom : tick());
    end
  endtask

  initial begin
    rst_n = 0; in_tvalid = 0; in_tdata = '0; in_tuser = '0;
    cfg_we = 0; cfg_addr = '0; cfg_wdata = '0;
    errors = 0; hold_off = 0; burst_left = 0; clock_ms = 0;
    s_valid = 0; s_ident = '0; s_delay = '0; s_since = '0; s_used = '0; s_retry_wait = 0;
    n_delayed = '0; worst = '0; warned = 0; warn_wait = 16'd1000; warn_depth = 7'd32;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_queue();
    write_reg(scqra_pkg::REG_WAIT_WARN, 16'hFFFF);
    write_reg(scqra_pkg::REG_DEPTH_WARN, 7'd1);
    test_random(10);
    write_reg(scqra_pkg::REG_WAIT_WARN, 16'd1500);
    write_reg(scqra_pkg::REG_DEPTH_WARN, 7'd4);
    test_random(14);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: shared_command_queue_retry_arbiter_top.f
rtl/core/scqra_pkg.sv
rtl/core/scqra_ram.sv
rtl/core/shared_command_queue_retry_arbiter_top.sv
tb/testbench.sv
